// ----- src/ata_pio_task_file_command_builder_unit_macros.svh -----
// Assertion macros shared by the checker of the task-file command builder.
`ifndef ATA_PIO_TASK_FILE_COMMAND_BUILDER_UNIT_MACROS_SVH
`define ATA_PIO_TASK_FILE_COMMAND_BUILDER_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define ATFCB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ATFCB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/atfcb_pkg.sv -----
// Types and constants of the ATA PIO task-file command builder.
package atfcb_pkg;

	// Configuration register indexes.
	localparam logic [2:0] CFG_DRIVE_PRESENT = 3'd0;
	localparam logic [2:0] CFG_USE_LBA48     = 3'd1;
	localparam logic [2:0] CFG_USE_LBA28     = 3'd2;
	localparam logic [2:0] CFG_CAPACITY      = 3'd3;
	localparam logic [2:0] CFG_HEADS         = 3'd4;
	localparam logic [2:0] CFG_SECTORS       = 3'd5;
	localparam logic [2:0] CFG_SLAVE         = 3'd6;

	// Addressing modes.
	localparam logic [1:0] MODE_LBA48 = 2'd0;
	localparam logic [1:0] MODE_LBA28 = 2'd1;
	localparam logic [1:0] MODE_CHS   = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_ABSENT   = 2'd1;
	localparam logic [1:0] ERR_COUNT    = 2'd2;
	localparam logic [1:0] ERR_CAPACITY = 2'd3;

	// Command-block register offsets.
	localparam logic [2:0] REG_NONE     = 3'd0;
	localparam logic [2:0] REG_FEATURES = 3'd1;
	localparam logic [2:0] REG_COUNT    = 3'd2;
	localparam logic [2:0] REG_LBA_LO   = 3'd3;
	localparam logic [2:0] REG_LBA_MID  = 3'd4;
	localparam logic [2:0] REG_LBA_HI   = 3'd5;
	localparam logic [2:0] REG_SELECT   = 3'd6;
	localparam logic [2:0] REG_COMMAND  = 3'd7;

	// Command bytes.
	localparam logic [7:0] CMD_READ      = 8'h20;
	localparam logic [7:0] CMD_WRITE     = 8'h30;
	localparam logic [7:0] CMD_READ_EXT  = 8'h24;
	localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

	localparam logic [7:0] SELECT_NONE = 8'hFF;
	localparam int         QDEPTH      = 2;

	// Classified request handed from the front to the back.
	typedef struct packed {
		logic        op_write;
		logic [1:0]  err;
		logic [1:0]  mode;
		logic [47:0] lba;
		logic [15:0] count;
		logic [3:0]  head;
		logic [7:0]  sect;
		logic [15:0] cyl;
	} desc_t;

	// Configuration as seen by the front and the back.
	typedef struct packed {
		logic        drive_present;
		logic        use_lba48;
		logic        use_lba28;
		logic [47:0] capacity;
		logic [4:0]  heads;
		logic [5:0]  sectors;
		logic        slave;
	} cfg_t;

endpackage

// ----- src/atfcb_front.sv -----
// Front part: accepts requests, checks them and computes CHS by serial division.
module atfcb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  atfcb_pkg::cfg_t     cfg,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [71:0]         s_tdata,
	input  logic                s_tuser,
	output logic                push,
	output atfcb_pkg::desc_t    push_desc,
	input  logic                q_full
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV1 = 2'd1;
	localparam logic [1:0] ST_DIV2 = 2'd2;
	localparam logic [1:0] ST_PUSH = 2'd3;

	logic [1:0]        state_q;
	atfcb_pkg::desc_t  desc_q;
	logic [47:0]       quo_q;
	logic [5:0]        rem_q;
	logic [5:0]        divisor_q;
	logic [5:0]        cnt_q;

	logic [47:0] in_lba;
	logic [16:0] in_cnt;
	logic [48:0] end_sum;
	logic [1:0]  err;
	logic [1:0]  mode;
	logic [5:0]  spt_eff;
	logic [5:0]  hpc_eff;
	logic [6:0]  rem_sh;
	logic        q_bit;
	logic [5:0]  rem_next;

	assign in_lba  = s_tdata[47:0];
	assign in_cnt  = s_tdata[64:48];
	assign end_sum = {1'b0, in_lba} + {32'd0, in_cnt};
	assign spt_eff = (cfg.sectors == 6'd0) ? 6'd1 : cfg.sectors;
	assign hpc_eff = (cfg.heads == 5'd0) ? 6'd1 : {1'b0, cfg.heads};

	// Addressing mode and request checks in priority order.
	always_comb begin
		if (cfg.use_lba48) begin
			mode = atfcb_pkg::MODE_LBA48;
		end else if (cfg.use_lba28) begin
			mode = atfcb_pkg::MODE_LBA28;
		end else begin
			mode = atfcb_pkg::MODE_CHS;
		end
		if (!cfg.drive_present) begin
			err = atfcb_pkg::ERR_ABSENT;
		end else if (!s_tuser && ({1'b0, cfg.capacity} < end_sum)) begin
			err = atfcb_pkg::ERR_CAPACITY;
		end else if (in_cnt == 17'd0) begin
			err = atfcb_pkg::ERR_COUNT;
		end else if (cfg.use_lba48 && in_cnt > 17'd65536) begin
			err = atfcb_pkg::ERR_COUNT;
		end else if (!cfg.use_lba48 && in_cnt > 17'd256) begin
			err = atfcb_pkg::ERR_COUNT;
		end else begin
			err = atfcb_pkg::ERR_OK;
		end
	end

	// One restoring division step.
	always_comb begin
		rem_sh = {rem_q, quo_q[47]};
		q_bit  = (rem_sh >= {1'b0, divisor_q});
		if (q_bit) begin
			rem_sh = rem_sh - {1'b0, divisor_q};
		end
		rem_next = rem_sh[5:0];
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign push      = (state_q == ST_PUSH) && !q_full;
	assign push_desc = desc_q;

	// Control sequence: classify, divide twice for CHS, then queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= (mode == atfcb_pkg::MODE_CHS && err == atfcb_pkg::ERR_OK)
							? ST_DIV1 : ST_PUSH;
					end
				end
				ST_DIV1: begin
					if (cnt_q == 6'd0) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (cnt_q == 6'd0) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Descriptor and divider datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				desc_q.op_write <= s_tuser;
				desc_q.err      <= err;
				desc_q.mode     <= mode;
				desc_q.lba      <= in_lba;
				desc_q.count    <= in_cnt[15:0];
				desc_q.head     <= in_lba[27:24];
				desc_q.sect     <= 8'd0;
				desc_q.cyl      <= 16'd0;
				quo_q           <= in_lba;
				rem_q           <= 6'd0;
				divisor_q       <= spt_eff;
				cnt_q           <= 6'd47;
			end
			ST_DIV1: begin
				if (cnt_q == 6'd0) begin
					// Sector is remainder plus one; the quotient feeds the head division.
					desc_q.sect <= {2'b00, rem_next} + 8'd1;
					quo_q       <= {quo_q[46:0], q_bit};
					rem_q       <= 6'd0;
					divisor_q   <= hpc_eff;
					cnt_q       <= 6'd47;
				end else begin
					quo_q <= {quo_q[46:0], q_bit};
					rem_q <= rem_next;
					cnt_q <= cnt_q - 6'd1;
				end
			end
			ST_DIV2: begin
				quo_q <= {quo_q[46:0], q_bit};
				rem_q <= rem_next;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					desc_q.cyl  <= quo_q[14:0] == 15'd0 ? {15'd0, q_bit} : {quo_q[14:0], q_bit};
					desc_q.head <= rem_next[3:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- src/atfcb_queue.sv -----
// Short queue of classified requests between the front and the back.
module atfcb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  atfcb_pkg::desc_t  push_desc,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output atfcb_pkg::desc_t  head_desc
);

	atfcb_pkg::desc_t entry_q [atfcb_pkg::QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full      = (fill_q == 2'(atfcb_pkg::QDEPTH));
	assign empty     = (fill_q == 2'd0);
	assign head_desc = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// ----- src/atfcb_back.sv -----
// Back part: walks a request's register writes into the output register.
module atfcb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              slave,
	input  logic              q_empty,
	input  atfcb_pkg::desc_t  head_desc,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,
	output logic              m_tlast
);

	atfcb_pkg::desc_t desc_q;
	logic        busy_q;
	logic [3:0]  step_q;
	logic [7:0]  last_sel_q;
	logic        ovalid_q;
	logic [2:0]  ooff_q;
	logic [7:0]  oval_q;
	logic [1:0]  oerr_q;
	logic        olast_q;

	logic        slot_free;
	logic        sel_skip;
	logic        emit;
	logic        lba_mode;
	logic [3:0]  sel_head;
	logic [7:0]  sel;
	logic [3:0]  final_step;
	logic [2:0]  item_off;
	logic [7:0]  item_val;
	logic [7:0]  cmd;

	assign slot_free = !ovalid_q || m_tready;
	assign pop       = !busy_q && !q_empty;
	assign lba_mode  = (desc_q.mode != atfcb_pkg::MODE_CHS);
	assign sel_head  = (desc_q.mode == atfcb_pkg::MODE_LBA48) ? 4'd0 : desc_q.head;
	assign sel       = {1'b1, lba_mode, 1'b1, slave, sel_head};
	assign final_step = (desc_q.mode == atfcb_pkg::MODE_LBA48) ? 4'd9 : 4'd6;

	// A valid request skips its drive-select write when the byte is unchanged.
	assign sel_skip = (desc_q.err == atfcb_pkg::ERR_OK) && (step_q == 4'd0) &&
		(sel == last_sel_q);
	// A new item enters the output register in this cycle.
	assign emit     = busy_q && slot_free && !sel_skip;

	// Command byte for the request's mode and direction.
	always_comb begin
		if (desc_q.mode == atfcb_pkg::MODE_LBA48) begin
			cmd = desc_q.op_write ? atfcb_pkg::CMD_WRITE_EXT : atfcb_pkg::CMD_READ_EXT;
		end else begin
			cmd = desc_q.op_write ? atfcb_pkg::CMD_WRITE : atfcb_pkg::CMD_READ;
		end
	end

	// Register write for the current step.
	always_comb begin
		item_off = atfcb_pkg::REG_NONE;
		item_val = 8'd0;
		if (desc_q.mode == atfcb_pkg::MODE_LBA48) begin
			case (step_q)
				4'd0: begin item_off = atfcb_pkg::REG_SELECT;  item_val = sel; end
				4'd1: begin item_off = atfcb_pkg::REG_COUNT;   item_val = desc_q.count[15:8]; end
				4'd2: begin item_off = atfcb_pkg::REG_LBA_LO;  item_val = desc_q.lba[31:24]; end
				4'd3: begin item_off = atfcb_pkg::REG_LBA_MID; item_val = desc_q.lba[39:32]; end
				4'd4: begin item_off = atfcb_pkg::REG_LBA_HI;  item_val = desc_q.lba[47:40]; end
				4'd5: begin item_off = atfcb_pkg::REG_COUNT;   item_val = desc_q.count[7:0]; end
				4'd6: begin item_off = atfcb_pkg::REG_LBA_LO;  item_val = desc_q.lba[7:0]; end
				4'd7: begin item_off = atfcb_pkg::REG_LBA_MID; item_val = desc_q.lba[15:8]; end
				4'd8: begin item_off = atfcb_pkg::REG_LBA_HI;  item_val = desc_q.lba[23:16]; end
				default: begin item_off = atfcb_pkg::REG_COMMAND; item_val = cmd; end
			endcase
		end else begin
			case (step_q)
				4'd0: begin item_off = atfcb_pkg::REG_SELECT;   item_val = sel; end
				4'd1: begin item_off = atfcb_pkg::REG_FEATURES; item_val = 8'd0; end
				4'd2: begin item_off = atfcb_pkg::REG_COUNT;    item_val = desc_q.count[7:0]; end
				4'd3: begin
					item_off = atfcb_pkg::REG_LBA_LO;
					item_val = lba_mode ? desc_q.lba[7:0] : desc_q.sect;
				end
				4'd4: begin
					item_off = atfcb_pkg::REG_LBA_MID;
					item_val = lba_mode ? desc_q.lba[15:8] : desc_q.cyl[7:0];
				end
				4'd5: begin
					item_off = atfcb_pkg::REG_LBA_HI;
					item_val = lba_mode ? desc_q.lba[23:16] : desc_q.cyl[15:8];
				end
				default: begin item_off = atfcb_pkg::REG_COMMAND; item_val = cmd; end
			endcase
		end
	end

	// Request register taken from the queue.
	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= head_desc;
		end
	end

	// Sequencer, drive-select memory and output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			step_q     <= 4'd0;
			last_sel_q <= atfcb_pkg::SELECT_NONE;
			ovalid_q   <= 1'b0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= 4'd0;
			end else if (busy_q && slot_free) begin
				if (desc_q.err != atfcb_pkg::ERR_OK) begin
					busy_q   <= 1'b0;
				end else if (sel_skip) begin
					step_q <= 4'd1;
				end else begin
					if (step_q == 4'd0) begin
						last_sel_q <= sel;
					end
					if (step_q == final_step) begin
						busy_q <= 1'b0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			if (desc_q.err != atfcb_pkg::ERR_OK) begin
				ooff_q  <= atfcb_pkg::REG_NONE;
				oval_q  <= 8'd0;
				oerr_q  <= desc_q.err;
				olast_q <= 1'b1;
			end else begin
				ooff_q  <= item_off;
				oval_q  <= item_val;
				oerr_q  <= atfcb_pkg::ERR_OK;
				olast_q <= (step_q == final_step);
			end
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {3'd0, oerr_q, oval_q, ooff_q};
	assign m_tlast  = olast_q;

endmodule

// ----- src/ata_pio_task_file_command_builder_unit.sv -----
// Top level of the ATA PIO task-file command builder.
// Usage:
// Each request on the slave stream (s_tdata: first_lba[47:0], sector_count[64:48];
// s_tuser: operation, 1 for write) becomes a run of task-file register writes on
// the master stream (m_tdata: reg_offset[2:0], reg_value[10:3], error_code[12:11]),
// with m_tlast on the last write of the run. A rejected request gives one item
// with offset 0 and the error code. Configuration is written through cfg_we,
// cfg_index and cfg_data while no request is in flight.
// LBA requests are checked combinationally on acceptance, then pass the front's
// descriptor register, the queue and the back's request register to the output
// register; CHS requests first pass two 48-step serial divisions. The back emits
// one write per cycle unless m_tready stalls the output: up to ten for LBA48, seven
// for LBA28 and CHS, one fewer when the drive-select write is skipped. The back
// sequencer and the CHS divider limit the request rate. A two-entry queue lets the
// front accept the next request while the back still works. When m_tready is low
// the output register holds and the back and then the front stall. Reset empties
// the queue, restores the reset configuration and marks no drive as selected.
module ata_pio_task_file_command_builder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // first_lba[47:0], sector_count[64:48], zero fill
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // reg_offset[2:0], reg_value[10:3], error_code[12:11]
	output logic        m_tlast
);

	atfcb_pkg::cfg_t  cfg_q;
	atfcb_pkg::desc_t push_desc;
	atfcb_pkg::desc_t head_desc;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_present <= 1'b0;
			cfg_q.use_lba48     <= 1'b0;
			cfg_q.use_lba28     <= 1'b0;
			cfg_q.capacity      <= 48'd0;
			cfg_q.heads         <= 5'd16;
			cfg_q.sectors       <= 6'd63;
			cfg_q.slave         <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				atfcb_pkg::CFG_DRIVE_PRESENT: cfg_q.drive_present <= cfg_data[0];
				atfcb_pkg::CFG_USE_LBA48:     cfg_q.use_lba48     <= cfg_data[0];
				atfcb_pkg::CFG_USE_LBA28:     cfg_q.use_lba28     <= cfg_data[0];
				atfcb_pkg::CFG_CAPACITY:      cfg_q.capacity      <= cfg_data;
				atfcb_pkg::CFG_HEADS:         cfg_q.heads         <= cfg_data[4:0];
				atfcb_pkg::CFG_SECTORS:       cfg_q.sectors       <= cfg_data[5:0];
				atfcb_pkg::CFG_SLAVE:         cfg_q.slave         <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	atfcb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_desc (push_desc),
		.q_full    (q_full)
	);

	atfcb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head_desc (head_desc)
	);

	atfcb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.slave     (cfg_q.slave),
		.q_empty   (q_empty),
		.head_desc (head_desc),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- src/atfcb_checker.sv -----
// Port-level checker of the task-file command builder and its bind.
`include "ata_pio_task_file_command_builder_unit_macros.svh"

module atfcb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// A stalled result stays offered with the same contents.
	`ATFCB_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`ATFCB_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
	// A rejection is a single item with no register offset.
	`ATFCB_ASSERT(a_err_last, m_tvalid && m_tdata[12:11] != 2'd0 |-> m_tlast && m_tdata[2:0] == 3'd0, "bad rejection item")
	// An accepted request never writes offset zero.
	`ATFCB_ASSERT(a_ok_offset, m_tvalid && m_tdata[12:11] == 2'd0 |-> m_tdata[2:0] != 3'd0, "write to offset zero")
	// Nothing is offered while reset is applied.
	`ATFCB_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_tvalid, "output valid in reset")

endmodule

bind ata_pio_task_file_command_builder_unit atfcb_checker u_atfcb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ----- dv/ata_pio_task_file_command_builder_unit_tb.sv -----
// Self-checking testbench of the ATA PIO task-file command builder.
module ata_pio_task_file_command_builder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import atfcb_pkg::*;

	// One task-file write as seen on the master stream.
	typedef struct packed {
		logic [2:0] offset;
		logic [7:0] value;
		logic [1:0] err;
		logic       last;
	} tf_write_t;

	// Scoreboard: predicts the writes of each request and checks the output.
	class tf_scoreboard;
		logic        present, lba48, lba28, slave;
		logic [47:0] capacity;
		logic [4:0]  heads;
		logic [5:0]  sectors;
		logic [7:0]  last_sel;
		tf_write_t   pending[$];
		int          errors;

		function void reset_state();
			present = 0; lba48 = 0; lba28 = 0; slave = 0;
			capacity = '0; heads = 16; sectors = 63;
			last_sel = SELECT_NONE;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [47:0] val);
			case (idx)
				CFG_DRIVE_PRESENT: present = val[0];
				CFG_USE_LBA48:     lba48 = val[0];
				CFG_USE_LBA28:     lba28 = val[0];
				CFG_CAPACITY:      capacity = val;
				CFG_HEADS:         heads = val[4:0];
				CFG_SECTORS:       sectors = val[5:0];
				CFG_SLAVE:         slave = val[0];
				default: ;
			endcase
		endfunction

		function void push(logic [2:0] off, logic [7:0] val);
			pending.push_back('{off, val, ERR_OK, 1'b0});
		endfunction

		function void push_select(logic lba, logic [3:0] head);
			logic [7:0] s;
			s = 8'hA0 | (lba ? 8'h40 : 8'h00) | {3'b0, slave, 4'b0} | {4'b0, head};
			if (s != last_sel) begin
				last_sel = s;
				push(REG_SELECT, s);
			end
		endfunction

		// Notes an accepted request and queues the writes it must produce.
		function void note_request(logic wr, logic [47:0] lba, logic [16:0] cnt);
			logic [48:0] endp;
			logic [63:0] hpc, spt, cyl, hd, sct;
			endp = {1'b0, lba} + {32'b0, cnt};
			if (!present) begin
				pending.push_back('{REG_NONE, 8'h00, ERR_ABSENT, 1'b1});
				return;
			end
			if (!wr && endp > {1'b0, capacity}) begin
				pending.push_back('{REG_NONE, 8'h00, ERR_CAPACITY, 1'b1});
				return;
			end
			if (cnt == 0 || cnt > (lba48 ? 17'd65536 : 17'd256)) begin
				pending.push_back('{REG_NONE, 8'h00, ERR_COUNT, 1'b1});
				return;
			end
			if (lba48) begin
				push_select(1'b1, 4'h0);
				push(REG_COUNT, cnt[15:8]);
				push(REG_LBA_LO, lba[31:24]);
				push(REG_LBA_MID, lba[39:32]);
				push(REG_LBA_HI, lba[47:40]);
				push(REG_COUNT, cnt[7:0]);
				push(REG_LBA_LO, lba[7:0]);
				push(REG_LBA_MID, lba[15:8]);
				push(REG_LBA_HI, lba[23:16]);
				push(REG_COMMAND, wr ? CMD_WRITE_EXT : CMD_READ_EXT);
			end else begin
				if (lba28) begin
					push_select(1'b1, lba[27:24]);
					push(REG_FEATURES, 8'h00);
					push(REG_COUNT, cnt[7:0]);
					push(REG_LBA_LO, lba[7:0]);
					push(REG_LBA_MID, lba[15:8]);
					push(REG_LBA_HI, lba[23:16]);
				end else begin
					hpc = (heads == 0) ? 1 : heads;
					spt = (sectors == 0) ? 1 : sectors;
					cyl = lba / (hpc * spt);
					hd = (lba / spt) % hpc;
					sct = (lba % spt) + 1;
					push_select(1'b0, hd[3:0]);
					push(REG_FEATURES, 8'h00);
					push(REG_COUNT, cnt[7:0]);
					push(REG_LBA_LO, sct[7:0]);
					push(REG_LBA_MID, cyl[7:0]);
					push(REG_LBA_HI, cyl[15:8]);
				end
				push(REG_COMMAND, wr ? CMD_WRITE : CMD_READ);
			end
			pending[$].last = 1'b1;
		endfunction

		// Compares one output write with the oldest expectation.
		function void check_write(tf_write_t got);
			tf_write_t exp_w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected write, actual %h", $realtime, got);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			if (got.offset != exp_w.offset) begin
				$display("%0t: offset expected %0d actual %0d", $realtime, exp_w.offset,
					got.offset);
				errors++;
			end
			if (got.value != exp_w.value) begin
				$display("%0t: value expected %h actual %h", $realtime, exp_w.value,
					got.value);
				errors++;
			end
			if (got.err != exp_w.err) begin
				$display("%0t: error code expected %0d actual %0d", $realtime, exp_w.err,
					got.err);
				errors++;
			end
			if (got.last != exp_w.last) begin
				$display("%0t: tlast expected %0b actual %0b", $realtime, exp_w.last,
					got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 1'b1;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	tf_scoreboard sb;
	int stall_mode = 0;

	ata_pio_task_file_command_builder_unit dut (.*);

	always #5 clk = ~clk;

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_write('{m_tdata[2:0], m_tdata[10:3], m_tdata[12:11], m_tlast});
	end

	// Receiver stalls: phases of no stall, light random stall and heavy random stall.
	always @(negedge clk) begin
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 2) != 0);
			default: m_tready <= ($urandom_range(0, 7) < 2);
		endcase
	end

	initial begin
		#20ms;
		$display("ata_pio_task_file_command_builder_unit_tb NOT OK");
		$finish;
	end

	// Writes one configuration register in the model and the block.
	task automatic set_reg(input logic [2:0] idx, input logic [47:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sends one request and waits for its acceptance, then a gap of the given length.
	task automatic send_request(input logic wr, input logic [47:0] lba,
			input logic [16:0] cnt, input int gap);
		s_tvalid <= 1'b1;
		s_tuser <= wr;
		s_tdata <= {7'b0, cnt, lba};
		do @(posedge clk); while (!s_tready);
		sb.note_request(wr, lba, cnt);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Waits for every expected write, then for the block to settle.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	// Random request: mostly counts within the mode's range.
	task automatic random_request(input int gap);
		logic [47:0] lba;
		logic [16:0] cnt;
		logic wr;
		wr = 1'($urandom_range(0, 1));
		lba = 48'({$urandom, $urandom});
		case ($urandom_range(0, 5))
			0: lba = lba & 48'hFFF;
			1: lba = sb.capacity - 48'($urandom_range(0, 300));
			default: ;
		endcase
		case ($urandom_range(0, 7))
			0: cnt = '0;
			1: cnt = 17'($urandom_range(0, 131071));
			2: cnt = sb.lba48 ? 17'd65536 : 17'd256;
			3: cnt = 17'($urandom_range(1, 65536));
			default: cnt = 17'($urandom_range(1, 256));
		endcase
		send_request(wr, lba, cnt, gap);
	endtask

	int burst;

	initial begin
		sb = new();
		sb.reset_state();
		arst_n <= 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// Directed: absent drive, then each mode with field extremes.
		send_request(1'b0, 48'h0, 17'd1, 0);
		send_request(1'b1, 48'hFFFF_FFFF_FFFF, 17'h1FFFF, 1);
		drain();
		set_reg(CFG_DRIVE_PRESENT, 48'd1);
		set_reg(CFG_USE_LBA48, 48'd1);
		set_reg(CFG_CAPACITY, 48'hFFFF_FFFF_FFFF);
		send_request(1'b0, 48'h0, 17'd65536, 0);
		send_request(1'b1, 48'hFFFF_FFFF_FFFF, 17'd65535, 0);
		send_request(1'b0, 48'hFFFF_FFFF_FFFF, 17'd1, 0);
		send_request(1'b1, 48'h1234_5678_9ABC, 17'd0, 0);
		send_request(1'b1, 48'h0, 17'd65537, 0);
		send_request(1'b1, 48'hA5A5_5A5A_A5A5, 17'h1FFFF, 2);
		drain();
		set_reg(CFG_USE_LBA48, 48'd0);
		set_reg(CFG_USE_LBA28, 48'd1);
		set_reg(CFG_SLAVE, 48'd1);
		set_reg(CFG_CAPACITY, 48'd1000);
		send_request(1'b0, 48'd744, 17'd256, 0);
		send_request(1'b0, 48'd745, 17'd256, 0);
		send_request(1'b1, 48'hFFFF_FFFF_FFFF, 17'd256, 0);
		send_request(1'b1, 48'h0F00_0000, 17'd257, 0);
		send_request(1'b1, 48'h0F00_0000, 17'd1, 3);
		drain();
		set_reg(CFG_USE_LBA28, 48'd0);
		set_reg(CFG_SLAVE, 48'd0);
		set_reg(CFG_CAPACITY, 48'hFFFF_FFFF_FFFF);
		send_request(1'b1, 48'hFFFF_FFFF_FFFF, 17'd1, 0);
		send_request(1'b0, 48'd0, 17'd256, 0);
		drain();
		set_reg(CFG_HEADS, 48'd0);
		set_reg(CFG_SECTORS, 48'd0);
		send_request(1'b1, 48'h0000_0012_3456, 17'd9, 0);
		drain();
		set_reg(CFG_HEADS, 48'd31);
		set_reg(CFG_SECTORS, 48'd1);
		send_request(1'b1, 48'd1000, 17'd9, 0);
		drain();
		set_reg(CFG_CAPACITY, 48'd0);
		send_request(1'b0, 48'd0, 17'd1, 0);
		drain();

		// Random phases over several settings.
		for (int ph = 0; ph < 8; ph++) begin
			stall_mode = ph % 3;
			set_reg(CFG_DRIVE_PRESENT, (ph == 5) ? 48'd0 : 48'd1);
			set_reg(CFG_USE_LBA48, 48'($urandom_range(0, 1)));
			set_reg(CFG_USE_LBA28, 48'($urandom_range(0, 1)));
			set_reg(CFG_SLAVE, 48'($urandom_range(0, 1)));
			set_reg(CFG_CAPACITY, (ph % 2) ? 48'hFFFF_FFFF_FFFF : 48'({$urandom, $urandom}));
			set_reg(CFG_HEADS, 48'($urandom_range(1, 16)));
			set_reg(CFG_SECTORS, (ph == 3) ? 48'd63 : 48'($urandom_range(1, 63)));
			for (int k = 0; k < 11; ) begin
				burst = $urandom_range(1, 5);
				for (int j = 0; j < burst; j++, k++)
					random_request((j == burst - 1) ? $urandom_range(1, 30) : 0);
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ata_pio_task_file_command_builder_unit_tb OK");
		else
			$display("ata_pio_task_file_command_builder_unit_tb NOT OK");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+src
src/atfcb_pkg.sv
src/atfcb_front.sv
src/atfcb_queue.sv
src/atfcb_back.sv
src/ata_pio_task_file_command_builder_unit.sv
src/atfcb_checker.sv
dv/ata_pio_task_file_command_builder_unit_tb.sv
